### sv/itp_pkg.sv
// Shared types, symbol codes and helper functions for the infix to postfix converter.
// No dependencies.

package itp_pkg;

    localparam int unsigned SYM_W = 8;

    localparam logic [SYM_W-1:0] SYM_END   = 8'h00;
    localparam logic [SYM_W-1:0] SYM_POW   = 8'h5E;
    localparam logic [SYM_W-1:0] SYM_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_DIV   = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_ADD   = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_SUB   = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h28;
    localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h29;
    localparam logic [SYM_W-1:0] SYM_UC_A  = 8'h41;
    localparam logic [SYM_W-1:0] SYM_UC_Z  = 8'h5A;
    localparam logic [SYM_W-1:0] SYM_LC_A  = 8'h61;
    localparam logic [SYM_W-1:0] SYM_LC_Z  = 8'h7A;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_CLOSE    = 3'd3,
        ST_OPEN     = 3'd4
    } t_status;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        t_status          status;
        logic             last;
    } t_emit;

    // 0 for anything that is not an operator
    function automatic logic [1:0] rank_of(input logic [SYM_W-1:0] c);
        logic [1:0] r;
        r = 2'd0;
        if (c == SYM_POW) begin
            r = 2'd3;
        end else if (c == SYM_MUL || c == SYM_DIV) begin
            r = 2'd2;
        end else if (c == SYM_ADD || c == SYM_SUB) begin
            r = 2'd1;
        end
        return r;
    endfunction

    function automatic logic is_letter(input logic [SYM_W-1:0] c);
        return (c >= SYM_UC_A && c <= SYM_UC_Z) || (c >= SYM_LC_A && c <= SYM_LC_Z);
    endfunction

endpackage

### sv/itp_stack_ram.sv
// Operator stack storage: one write port, one read port, registered read data.
// Depends on itp_pkg for the symbol width.

module itp_stack_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [itp_pkg::SYM_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic [itp_pkg::SYM_W-1:0] o_rdata
);
    import itp_pkg::*;

    logic [SYM_W-1:0] r_mem [DEPTH];
    logic [SYM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/itp_seq.sv
// Shunting-yard sequencer: takes one symbol, then pops/pushes the stack one entry a cycle
// while the output is free. Depends on itp_pkg; drives the ports of itp_stack_ram.

module itp_seq #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5,
    parameter int unsigned CW    = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [itp_pkg::SYM_W-1:0] i_symbol,
    input  logic                      i_out_free,
    output logic                      o_emit_valid,
    output itp_pkg::t_emit            o_emit,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic [itp_pkg::SYM_W-1:0] o_wdata,
    output logic [AW-1:0]             o_raddr,
    input  logic [itp_pkg::SYM_W-1:0] i_rdata
);
    import itp_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_WORK
    } t_state;

    t_state           r_state, n_state;
    logic [SYM_W-1:0] r_sym, n_sym;
    logic [CW-1:0]    r_count, n_count;
    logic [SYM_W-1:0] r_top, n_top;    // copy of the top entry, valid while r_count != 0

    logic          emit_v;
    t_emit         emit;
    logic          we;
    logic [AW-1:0] waddr;
    logic          go;
    logic          full;
    logic          has_below;          // i_rdata holds the entry under the top
    logic [1:0]    sym_rank;
    logic          top_pops;
    logic          below_pops;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] count_m2;

    assign full       = (r_count == CW'(DEPTH));
    assign has_below  = (r_count >= CW'(2));
    assign sym_rank   = rank_of(r_sym);
    assign top_pops   = (rank_of(r_top) != 2'd0) && (rank_of(r_top) >= sym_rank);
    assign below_pops = (rank_of(i_rdata) != 2'd0) && (rank_of(i_rdata) >= sym_rank);
    assign count_m1   = r_count - CW'(1);

    always_comb begin
        n_state = r_state;
        n_sym   = r_sym;
        n_count = r_count;
        n_top   = r_top;
        emit_v  = 1'b0;
        emit    = '{sym: SYM_END, status: ST_OK, last: 1'b1};
        we      = 1'b0;
        waddr   = r_count[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sym   = i_symbol;
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                n_state = S_IDLE;
                if (r_sym == SYM_END) begin
                    if (r_count != '0) begin
                        emit_v      = 1'b1;
                        emit.sym    = (r_top == SYM_OPEN) ? SYM_END : r_top;
                        emit.status = (r_top == SYM_OPEN) ? ST_OPEN : ST_OK;
                        emit.last   = (r_count == CW'(1));
                        n_count     = count_m1;
                        n_top       = i_rdata;
                        if (r_count != CW'(1)) begin
                            n_state = S_WORK;
                        end
                    end else begin
                        emit_v = 1'b1;
                    end
                end else if (is_letter(r_sym)) begin
                    emit_v   = 1'b1;
                    emit.sym = r_sym;
                end else if (r_sym == SYM_CLOSE) begin
                    if (r_count == '0) begin
                        emit_v      = 1'b1;
                        emit.status = ST_CLOSE;
                    end else if (r_top == SYM_OPEN) begin
                        n_count = count_m1;
                        n_top   = i_rdata;
                    end else begin
                        emit_v    = 1'b1;
                        emit.sym  = r_top;
                        emit.last = has_below && (i_rdata == SYM_OPEN);
                        n_count   = count_m1;
                        n_top     = i_rdata;
                        n_state   = S_WORK;
                    end
                end else if (r_sym == SYM_OPEN || sym_rank != 2'd0) begin
                    if (sym_rank != 2'd0 && r_count != '0 && top_pops) begin
                        emit_v    = 1'b1;
                        emit.sym  = r_top;
                        emit.last = !(has_below && below_pops);
                        if (emit.last) begin
                            // pop and push in one go: the new operator replaces the top
                            we    = 1'b1;
                            waddr = count_m1[AW-1:0];
                            n_top = r_sym;
                        end else begin
                            n_count = count_m1;
                            n_top   = i_rdata;
                            n_state = S_WORK;
                        end
                    end else if (full) begin
                        emit_v      = 1'b1;
                        emit.status = ST_OVERFLOW;
                    end else begin
                        we      = 1'b1;
                        n_count = r_count + CW'(1);
                        n_top   = r_sym;
                    end
                end else begin
                    emit_v      = 1'b1;
                    emit.status = ST_INVALID;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hold everything while a result cannot leave
        go = !emit_v || i_out_free;
        if (!go) begin
            n_state = r_state;
            n_count = r_count;
            n_top   = r_top;
            we      = 1'b0;
        end
    end

    // Read the entry under the next top; write goes to n_count-1, never the same address.
    assign count_m2 = n_count - CW'(2);
    assign o_raddr  = (n_count >= CW'(2)) ? count_m2[AW-1:0] : '0;

    assign o_we         = we;
    assign o_waddr      = waddr;
    assign o_wdata      = r_sym;
    assign o_emit_valid = emit_v && go;
    assign o_emit       = emit;
    assign o_in_stall   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_sym <= n_sym;
        r_top <= n_top;
    end

endmodule

### sv/infix_to_postfix_converter_top.sv
// Infix to postfix converter: one input symbol a beat, postfix symbols and status out.
// An input symbol is registered, then handled in the work state; results go to the output register.
// A new symbol is taken only while the sequencer is idle; the stack is popped one entry a cycle
// while the output is free, and output stalls hold the sequencer.
// Reset empties the stack and drops any pending output beat; stack memory is not cleared.
// Depends on itp_pkg, itp_stack_ram, itp_seq.

module infix_to_postfix_converter_top #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [itp_pkg::SYM_W-1:0] i_symbol,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [itp_pkg::SYM_W-1:0] o_out_symbol,
    output logic [2:0]                o_status,
    output logic                      o_last
);
    import itp_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    logic             emit_valid;
    t_emit            emit;
    logic             out_free;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [SYM_W-1:0] wdata;
    logic [AW-1:0]    raddr;
    logic [SYM_W-1:0] rdata;

    logic  r_out_valid;
    t_emit r_out;

    itp_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    itp_seq #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_symbol     (i_symbol),
        .i_out_free   (out_free),
        .o_emit_valid (emit_valid),
        .o_emit       (emit),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    // output register: holds a result beat until the consumer takes it
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (emit_valid) begin
            r_out <= emit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_symbol = r_out.sym;
    assign o_status     = r_out.status;
    assign o_last       = r_out.last;

endmodule

### tb/itp_tb_checker.sv
// Checker for the infix to postfix converter: watches both channels, keeps its own
// operator stack to predict the postfix beats, and compares every output beat in order.
// Depends on itp_pkg.

module itp_tb_checker #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [itp_pkg::SYM_W-1:0] i_symbol,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [itp_pkg::SYM_W-1:0] i_out_symbol,
    input  logic [2:0]                i_status,
    input  logic                      i_last,
    output int unsigned               o_pending,
    output int unsigned               o_fail_count
);
    import itp_pkg::*;

    logic [SYM_W-1:0] op_stack [STACK_DEPTH];
    int unsigned      held_ops = 0;
    t_emit            postfix_q [$];
    int unsigned      mismatch_cnt = 0;

    function automatic int unsigned precedence(input logic [SYM_W-1:0] c);
        case (c)
            SYM_POW:          return 3;
            SYM_MUL, SYM_DIV: return 2;
            SYM_ADD, SYM_SUB: return 1;
            default:          return 0;
        endcase
    endfunction

    // folding in bit 5 maps upper case onto lower case and nothing else into a..z
    function automatic logic letter(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] folded;
        folded = c | 8'h20;
        return folded >= SYM_LC_A && folded <= SYM_LC_Z;
    endfunction

    function automatic void emit_beat(input logic [SYM_W-1:0] s, input t_status st);
        t_emit b;
        b.sym    = s;
        b.status = st;
        b.last   = 1'b0;
        postfix_q.push_back(b);
    endfunction

    // a full stack drops the symbol and flags overflow
    function automatic void push_op(input logic [SYM_W-1:0] c);
        if (held_ops < STACK_DEPTH) begin
            op_stack[held_ops] = c;
            held_ops++;
        end else begin
            emit_beat('0, ST_OVERFLOW);
        end
    endfunction

    function automatic void predict_postfix(input logic [SYM_W-1:0] c);
        int unsigned      first;
        int unsigned      rank;
        logic [SYM_W-1:0] top_op;
        logic             matched;
        first = postfix_q.size();
        if (c == SYM_END) begin
            while (held_ops > 0) begin
                held_ops--;
                top_op = op_stack[held_ops];
                if (top_op == SYM_OPEN) begin
                    emit_beat('0, ST_OPEN);
                end else begin
                    emit_beat(top_op, ST_OK);
                end
            end
            if (postfix_q.size() == first) begin
                emit_beat('0, ST_OK);
            end
        end else if (letter(c)) begin
            emit_beat(c, ST_OK);
        end else if (c == SYM_OPEN) begin
            push_op(c);
        end else if (precedence(c) != 0) begin
            rank = precedence(c);
            // '(' has precedence 0, so it stops the walk
            while (held_ops > 0 && precedence(op_stack[held_ops-1]) >= rank) begin
                held_ops--;
                emit_beat(op_stack[held_ops], ST_OK);
            end
            push_op(c);
        end else if (c == SYM_CLOSE) begin
            matched = 1'b0;
            while (held_ops > 0 && !matched) begin
                held_ops--;
                top_op = op_stack[held_ops];
                if (top_op == SYM_OPEN) begin
                    matched = 1'b1;
                end else begin
                    emit_beat(top_op, ST_OK);
                end
            end
            if (!matched) begin
                emit_beat('0, ST_CLOSE);
            end
        end else begin
            emit_beat('0, ST_INVALID);
        end
        if (postfix_q.size() > first) begin
            postfix_q[postfix_q.size()-1].last = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_emit exp_beat;
        if (!i_rst_n) begin
            held_ops = 0;
            postfix_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_postfix(i_symbol);
            end
            if (i_out_valid && !i_out_stall) begin
                if (postfix_q.size() == 0) begin
                    if (mismatch_cnt < 10) begin
                        $display("unexpected beat: sym %h status %0d last %b",
                                 i_out_symbol, i_status, i_last);
                    end
                    mismatch_cnt++;
                end else begin
                    exp_beat = postfix_q.pop_front();
                    if (i_out_symbol !== exp_beat.sym || i_status !== exp_beat.status ||
                        i_last !== exp_beat.last) begin
                        if (mismatch_cnt < 10) begin
                            $display("beat mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     exp_beat.sym, exp_beat.status, exp_beat.last,
                                     i_out_symbol, i_status, i_last);
                        end
                        mismatch_cnt++;
                    end
                end
            end
        end
        o_pending    <= postfix_q.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

### tb/tb_top.sv
// Testbench top for the infix to postfix converter: clock, reset, symbol stimulus,
// output stalls and the verdict. Depends on itp_pkg, itp_tb_checker and the converter RTL.

module tb_top;
    import itp_pkg::*;

    localparam int unsigned STACK_DEPTH  = 32;
    localparam int unsigned ITEM_TARGET  = 470;
    localparam int unsigned CALM_TAIL    = 60;
    localparam int unsigned PRESS_AT     = 150;
    localparam int unsigned HOLD_LEN     = 300;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic [SYM_W-1:0] symbol    = '0;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic [SYM_W-1:0] out_symbol;
    logic [2:0]       out_status;
    logic             out_last;
    int unsigned      pending;
    int unsigned      fail_count;

    bit               src_idle_on   = 1'b1;
    bit               src_gaps      = 1'b1;
    bit               sink_idle_on  = 1'b1;
    bit               hold_req      = 1'b0;
    bit               pressure_done = 1'b0;
    int unsigned      beats_sent    = 0;
    int unsigned      cycle_count   = 0;
    int unsigned      hold_cycles;
    logic [SYM_W-1:0] expr_q [$];

    logic [SYM_W-1:0] op_set [5] = '{SYM_POW, SYM_MUL, SYM_DIV, SYM_ADD, SYM_SUB};

    // precedence walk, unmatched close/open, empty end, and the bytes around the letters
    logic [SYM_W-1:0] directed [24] = '{
        SYM_END,
        SYM_UC_A, SYM_ADD, SYM_UC_Z, SYM_MUL, SYM_LC_A, SYM_SUB, SYM_LC_Z, SYM_DIV,
        SYM_OPEN, SYM_UC_A, SYM_POW, SYM_LC_Z, SYM_CLOSE, SYM_END,
        SYM_CLOSE,
        SYM_OPEN, SYM_END,
        SYM_UC_A - 8'd1, SYM_UC_Z + 8'd1, SYM_LC_A - 8'd1, SYM_LC_Z + 8'd1, 8'hFF, 8'h01
    };

    always #2 clk = ~clk;

    infix_to_postfix_converter_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_symbol    (symbol),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_symbol(out_symbol),
        .o_status    (out_status),
        .o_last      (out_last)
    );

    itp_tb_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_symbol    (symbol),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_symbol(out_symbol),
        .i_status    (out_status),
        .i_last      (out_last),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    function automatic logic [SYM_W-1:0] rand_letter();
        if ($urandom_range(0, 1) != 0) begin
            return SYM_UC_A + 8'($urandom_range(0, 25));
        end
        return SYM_LC_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic void add_wellformed(input int unsigned max_terms);
        int unsigned terms;
        int unsigned depth;
        terms = $urandom_range(1, max_terms);
        depth = 0;
        for (int unsigned t = 0; t < terms; t++) begin
            while (depth < 12 && $urandom_range(0, 3) == 0) begin
                expr_q.push_back(SYM_OPEN);
                depth++;
            end
            expr_q.push_back(rand_letter());
            while (depth > 0 && $urandom_range(0, 2) == 0) begin
                expr_q.push_back(SYM_CLOSE);
                depth--;
            end
            if (t + 1 < terms) begin
                expr_q.push_back(op_set[$urandom_range(0, 4)]);
            end
        end
        repeat (depth) expr_q.push_back(SYM_CLOSE);
        expr_q.push_back(SYM_END);
    endfunction

    // a legal expression with one stray symbol dropped in somewhere
    function automatic void add_broken();
        int unsigned pos;
        add_wellformed(6);
        pos = $urandom_range(0, expr_q.size() - 1);
        case ($urandom_range(0, 3))
            0:       expr_q.insert(pos, SYM_CLOSE);
            1:       expr_q.insert(pos, SYM_OPEN);
            2:       expr_q.insert(pos, 8'($urandom_range(1, 255)));
            default: expr_q.insert(pos, SYM_END);
        endcase
    endfunction

    // mostly pushes, so the stack runs near or past full before the flush
    function automatic void add_deep();
        repeat ($urandom_range(28, 40)) begin
            expr_q.push_back(($urandom_range(0, 2) != 0) ? SYM_OPEN : op_set[$urandom_range(0, 4)]);
        end
        expr_q.push_back(rand_letter());
        repeat ($urandom_range(0, 3)) expr_q.push_back(SYM_CLOSE);
        expr_q.push_back(SYM_END);
    endfunction

    function automatic void add_noise();
        repeat ($urandom_range(1, 6)) expr_q.push_back(8'($urandom_range(0, 255)));
        expr_q.push_back(SYM_END);
    endfunction

    task automatic send_beat(input logic [SYM_W-1:0] sym);
        if (src_idle_on && src_gaps && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= sym;
        do @(posedge clk); while (in_stall);
        beats_sent++;
    endtask

    // the checker's count is registered, hence the step before looking at it
    task automatic wait_all_out();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // output side: random stall bursts, calm stretches, and one long hold on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                for (hold_cycles = 0; hold_cycles < HOLD_LEN; hold_cycles++) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 15) == 0) begin
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        bit          press_now;
        int unsigned kind;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i]) send_beat(directed[i]);
        wait_all_out();

        while (beats_sent < ITEM_TARGET) begin
            if (beats_sent + CALM_TAIL >= ITEM_TARGET) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            press_now = !pressure_done && beats_sent >= PRESS_AT;
            src_gaps  = !press_now && $urandom_range(0, 3) != 0;
            expr_q.delete();
            if (press_now) begin
                // keep offering beats while the output is held so the block backs up
                hold_req = 1'b1;
                add_wellformed(20);
                add_wellformed(20);
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 65) begin
                    add_wellformed(8);
                end else if (kind < 77) begin
                    add_broken();
                end else if (kind < 85) begin
                    add_noise();
                end else if (kind < 92) begin
                    add_deep();
                end else begin
                    add_wellformed(20);
                end
            end
            foreach (expr_q[i]) send_beat(expr_q[i]);
            if (press_now) begin
                pressure_done = 1'b1;
                wait_all_out();
            end else if (src_idle_on && $urandom_range(0, 9) == 0) begin
                wait_all_out();
            end
        end

        wait_all_out();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
